// ===== src/lcsd_pkg.sv =====
// Shared types and constants for the LED cube scan driver.
`timescale 1ns / 1ps
package lcsd_pkg;

  localparam int CubeSideDflt = 8;

  localparam logic [15:0] DwellReset = 16'd500;
  localparam logic [19:0] FrameReset = 20'd20000;
  localparam logic [19:0] SinceMax   = 20'hFFFFF;

  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpWrite   = 2'd1;
  localparam logic [1:0] OpAllOn   = 2'd2;
  localparam logic [1:0] OpAllOff  = 2'd3;

  localparam logic RegDwell = 1'b0;
  localparam logic RegFrame = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] column;
    logic [2:0] layer;
    logic [7:0] row_bits;
  } in_req_t;

  typedef struct packed {
    logic [7:0] row_data;
    logic [7:0] latch_strobe;
    logic [7:0] layer_enable;
    logic       scan_active;
  } out_rsp_t;

endpackage

// ===== src/led_cube_scan_driver_top.sv =====
// Top level of the LED cube scan driver: request decode, scan sequencer, result stages.
//
// Requests arrive on in_valid_i/in_ready_o with an in_req_t payload: a scan
// tick, a word write, all on or all off. Only scan ticks return a result on
// out_valid_o/out_ready_i; the other requests update the display store at once.
// One request is taken per cycle while in_ready_o is high. The edge that takes a
// tick registers the display store read; the output register is loaded when the
// read stage advances, which a stalled receiver can delay.
// A tick during latching drives one column word with its one-hot strobe; a tick
// during dwell drives the layer enable; an idle tick returns all zero.
// When the receiver stalls, the output register holds and one more result
// waits in the read stage; in_ready_o drops only when both are full.
// Reset clears the scan state, sets the frame counter so the first tick starts
// a scan, and marks every store word as reading dark through per-word valid
// bits; no clearing pass is needed. All on and all off act at once by
// clearing the valid bits and setting the fill value.
// Configuration: dwell_ticks at address 0, frame_ticks at address 4, to be written through
// the APB port only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module led_cube_scan_driver_top #(
  parameter int CUBE_SIDE = lcsd_pkg::CubeSideDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lcsd_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lcsd_pkg::out_rsp_t out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import lcsd_pkg::*;

  localparam int Depth = CUBE_SIDE * CUBE_SIDE;
  localparam int AW    = $clog2(Depth);
  localparam int LW    = $clog2(CUBE_SIDE);
  localparam int CW    = $clog2(CUBE_SIDE + 1);
  localparam int RowW  = (CUBE_SIDE < 8) ? CUBE_SIDE : 8;
  localparam logic [RowW-1:0] RowMask = {RowW{1'b1}};

  // configuration
  logic [15:0] dwell_q;
  logic [19:0] frame_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegFrame) ? 32'(frame_q) : 32'(dwell_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= DwellReset;
      frame_q <= FrameReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegDwell) begin
        dwell_q <= pwdata[15:0];
      end else begin
        frame_q <= pwdata[19:0];
      end
    end
  end

  // handshake and stages
  logic s1_v_q, out_v_q, s2_free, s1_adv, in_acc, tick_acc;

  assign s2_free    = !out_v_q || out_ready_i;
  assign s1_adv     = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s2_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign tick_acc   = in_acc && (in_req_i.op == OpTick);

  // display store: RAM plus valid bits and fill value
  logic [Depth-1:0] vld_q, vld_d;
  logic [RowW-1:0]  fill_q, fill_d;
  logic             wr_ok, ram_we;
  logic [AW-1:0]    waddr, raddr;
  logic [RowW-1:0]  rdata;

  assign wr_ok  = (32'(in_req_i.column) < CUBE_SIDE) && (32'(in_req_i.layer) < CUBE_SIDE);
  assign ram_we = in_acc && (in_req_i.op == OpWrite) && wr_ok;
  assign waddr  = AW'(32'(in_req_i.layer) * CUBE_SIDE + 32'(in_req_i.column));

  always_comb begin
    vld_d  = vld_q;
    fill_d = fill_q;
    if (in_acc) begin
      case (in_req_i.op)
        OpWrite: begin
          if (wr_ok) begin
            vld_d[waddr] = 1'b1;
          end
        end
        OpAllOn: begin
          vld_d  = '0;
          fill_d = RowMask;
        end
        OpAllOff: begin
          vld_d  = '0;
          fill_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      fill_q <= '0;
    end else begin
      vld_q  <= vld_d;
      fill_q <= fill_d;
    end
  end

  // scan sequencer
  logic          scanning_q, scanning_d;
  logic [LW-1:0] layer_q, layer_d, lay_cur;
  logic [CW-1:0] col_q, col_d, col_cur, col_lat;
  logic [15:0]   dcnt_q, dcnt_d, dcnt_dec;
  logic [19:0]   since_q, since_d, since_mid;
  logic          start, scan_now, latch, dwell_ph;
  logic [7:0]    strobe, enable;

  assign start    = !scanning_q && (since_q >= frame_q);
  assign scan_now = scanning_q || start;
  assign lay_cur  = start ? '0 : layer_q;
  assign col_cur  = start ? '0 : col_q;
  assign latch    = scan_now && (col_cur < CW'(CUBE_SIDE));
  assign dwell_ph = scan_now && !latch;
  assign col_lat  = latch ? col_cur : '0;
  assign raddr    = AW'(32'(lay_cur) * CUBE_SIDE + 32'(col_lat));
  assign dcnt_dec = (dcnt_q != '0) ? dcnt_q - 16'd1 : dcnt_q;
  assign since_mid = start ? '0 : since_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      strobe[i] = latch && (32'(col_cur) == i);
      enable[i] = dwell_ph && (32'(lay_cur) == i);
    end
  end

  always_comb begin
    scanning_d = scanning_q;
    layer_d    = layer_q;
    col_d      = col_q;
    dcnt_d     = dcnt_q;
    since_d    = since_q;
    if (tick_acc) begin
      scanning_d = scan_now;
      layer_d    = lay_cur;
      col_d      = col_cur;
      since_d    = (since_mid != SinceMax) ? since_mid + 20'd1 : since_mid;
      if (latch) begin
        col_d = col_cur + CW'(1);
        if (col_d >= CW'(CUBE_SIDE)) begin
          dcnt_d = (dwell_q != '0) ? dwell_q : 16'd1;
        end
      end else if (dwell_ph) begin
        dcnt_d = dcnt_dec;
        if (dcnt_dec == '0) begin
          col_d = '0;
          if (lay_cur == LW'(CUBE_SIDE - 1)) begin
            scanning_d = 1'b0;
            layer_d    = '0;
          end else begin
            layer_d = lay_cur + LW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q <= 1'b0;
      layer_q    <= '0;
      col_q      <= '0;
      dcnt_q     <= '0;
      since_q    <= SinceMax;
    end else begin
      scanning_q <= scanning_d;
      layer_q    <= layer_d;
      col_q      <= col_d;
      dcnt_q     <= dcnt_d;
      since_q    <= since_d;
    end
  end

  lcsd_ram #(
    .Width (RowW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_req_i.row_bits[RowW-1:0]),
    .re_i    (tick_acc),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // read stage
  logic            s1_latch_q, s1_hit_q, s1_active_q;
  logic [RowW-1:0] s1_fill_q;
  logic [7:0]      s1_strobe_q, s1_enable_q;
  logic [RowW-1:0] s1_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (tick_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_latch_q  <= latch;
      s1_hit_q    <= vld_q[raddr];
      s1_fill_q   <= fill_q;
      s1_strobe_q <= strobe;
      s1_enable_q <= enable;
      s1_active_q <= scan_now;
    end
  end

  assign s1_row = !s1_latch_q ? '0 : (s1_hit_q ? rdata : s1_fill_q);

  // output register
  out_rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.row_data     <= 8'(s1_row);
      out_q.latch_strobe <= s1_strobe_q;
      out_q.layer_enable <= s1_enable_q;
      out_q.scan_active  <= s1_active_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

  // checks
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= CW'(CUBE_SIDE))
    else $error("scan column beyond dwell code");

  a_strobe_enable_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.latch_strobe == 8'd0 || out_q.layer_enable == 8'd0))
    else $error("latch strobe and layer enable together");

  a_idle_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.scan_active) |->
      (out_q.row_data == 8'd0 && out_q.latch_strobe == 8'd0 && out_q.layer_enable == 8'd0))
    else $error("idle tick drives lines");

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ($onehot0(out_q.latch_strobe) && $onehot0(out_q.layer_enable)))
    else $error("strobe or enable not one-hot");

  a_dwell_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scanning_q && col_q == CW'(CUBE_SIDE)) |-> (dcnt_q != 16'd0))
    else $error("dwell phase with zero count");

endmodule

// ===== src/lcsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lcsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the LED cube scan driver: random requests, scan prediction, APB setup.
`timescale 1ns / 1ps
module tb_top;
  import lcsd_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_req_t     in_req_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_rsp_t    out_rsp_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  led_cube_scan_driver_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predicted cube state
  logic [7:0]  cube_words [64];
  logic [2:0]  scan_layer;
  logic [3:0]  scan_col;
  logic [15:0] dwell_left;
  logic [19:0] since_scan;
  logic        scanning;
  logic [15:0] dwell_cfg;
  logic [19:0] frame_cfg;

  in_req_t  pending_req_q [$];
  out_rsp_t scan_expect_q [$];
  int       mismatch_cnt = 0;
  bit       idle_on      = 1'b1;
  int       send_gap     = 0;
  int       recv_wait    = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, 6)) : 0;
  endfunction

  function automatic in_req_t mk_req(input logic [1:0] op, input logic [2:0] col,
                                     input logic [2:0] lay, input logic [7:0] bits);
    in_req_t r;
    r.op       = op;
    r.column   = col;
    r.layer    = lay;
    r.row_bits = bits;
    return r;
  endfunction

  function automatic in_req_t rand_req();
    in_req_t r;
    int      pick;
    r.column   = 3'($urandom_range(0, 7));
    r.layer    = 3'($urandom_range(0, 7));
    r.row_bits = 8'($urandom_range(0, 255));
    pick       = int'($urandom_range(0, 99));
    if (pick < 24) r.op = OpWrite;
    else if (pick < 27) r.op = OpAllOn;
    else if (pick < 30) r.op = OpAllOff;
    else r.op = OpTick;
    return r;
  endfunction

  function automatic void predict_scan(input in_req_t r);
    out_rsp_t e;
    int       k;
    e = '0;
    case (r.op)
      OpWrite: begin
        cube_words[{r.layer, r.column}] = r.row_bits;
      end
      OpAllOn: begin
        for (k = 0; k < 64; k++) cube_words[k] = 8'hFF;
      end
      OpAllOff: begin
        for (k = 0; k < 64; k++) cube_words[k] = 8'h00;
      end
      default: begin
        if (!scanning && since_scan >= frame_cfg) begin
          scanning   = 1'b1;
          scan_layer = '0;
          scan_col   = '0;
          since_scan = '0;
        end
        if (scanning) begin
          e.scan_active = 1'b1;
          if (scan_col < 4'd8) begin
            e.row_data     = cube_words[{scan_layer, scan_col[2:0]}];
            e.latch_strobe = 8'b1 << scan_col[2:0];
            scan_col++;
            if (scan_col == 4'd8) dwell_left = (dwell_cfg == '0) ? 16'd1 : dwell_cfg;
          end else begin
            e.layer_enable = 8'b1 << scan_layer;
            if (dwell_left != '0) dwell_left--;
            if (dwell_left == '0) begin
              if (scan_layer == 3'd7) scanning = 1'b0;
              scan_layer = scan_layer + 3'd1;
              scan_col   = '0;
            end
          end
        end
        if (since_scan != SinceMax) since_scan++;
        scan_expect_q.push_back(e);
      end
    endcase
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_scan(in_req_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          in_req_i   <= pending_req_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    out_rsp_t want;
    int       w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (scan_expect_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_rsp_o), '0);
      end else begin
        want = scan_expect_q.pop_front();
        if (out_rsp_o.row_data !== want.row_data)
          report_mismatch("row_data", 32'(out_rsp_o.row_data), 32'(want.row_data));
        if (out_rsp_o.latch_strobe !== want.latch_strobe)
          report_mismatch("latch_strobe", 32'(out_rsp_o.latch_strobe),
                          32'(want.latch_strobe));
        if (out_rsp_o.layer_enable !== want.layer_enable)
          report_mismatch("layer_enable", 32'(out_rsp_o.layer_enable),
                          32'(want.layer_enable));
        if (out_rsp_o.scan_active !== want.scan_active)
          report_mismatch("scan_active", 32'(out_rsp_o.scan_active),
                          32'(want.scan_active));
      end
      w = draw_wait();
      recv_wait   <= w;
      out_ready_i <= (w == 0);
    end else if (recv_wait != 0) begin
      recv_wait   <= recv_wait - 1;
      out_ready_i <= (recv_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic drain_requests(input int settle);
    while (pending_req_q.size() != 0 || in_valid_i || scan_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic reg_sel, input logic [31:0] value);
    logic [31:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (reg_sel == RegDwell) dwell_cfg = value[15:0];
    else frame_cfg = value[19:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    want = (reg_sel == RegDwell) ? {16'h0, dwell_cfg} : {12'h0, frame_cfg};
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] dwell, input logic [19:0] frame,
                           input int n_items, input bit idling);
    set_reg(RegDwell, {16'h0, dwell});
    set_reg(RegFrame, {12'h0, frame});
    idle_on = idling;
    repeat (n_items) pending_req_q.push_back(rand_req());
    drain_requests(4);
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    foreach (cube_words[k]) cube_words[k] = 8'h00;
    scan_layer = '0;
    scan_col   = '0;
    dwell_left = '0;
    since_scan = SinceMax;
    scanning   = 1'b0;
    dwell_cfg  = DwellReset;
    frame_cfg  = FrameReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner words plus column 1 of layer 0, then a scan through fill changes into the first dwell
    pending_req_q.push_back(mk_req(OpWrite, 3'd0, 3'd0, 8'hFF));
    pending_req_q.push_back(mk_req(OpWrite, 3'd7, 3'd0, 8'h80));
    pending_req_q.push_back(mk_req(OpWrite, 3'd1, 3'd0, 8'h01));
    pending_req_q.push_back(mk_req(OpWrite, 3'd7, 3'd7, 8'hFF));
    pending_req_q.push_back(mk_req(OpWrite, 3'd0, 3'd7, 8'h7F));
    repeat (4) pending_req_q.push_back(mk_req(OpTick, 3'd7, 3'd7, 8'hFF));
    pending_req_q.push_back(mk_req(OpAllOn, 3'd0, 3'd0, 8'h00));
    repeat (2) pending_req_q.push_back(mk_req(OpTick, 3'd0, 3'd0, 8'h00));
    pending_req_q.push_back(mk_req(OpAllOff, 3'd7, 3'd7, 8'hFF));
    repeat (2) pending_req_q.push_back(mk_req(OpTick, 3'd0, 3'd0, 8'h00));
    pending_req_q.push_back(mk_req(OpWrite, 3'd2, 3'd1, 8'hA5));
    repeat (2) pending_req_q.push_back(mk_req(OpTick, 3'd0, 3'd0, 8'h00));
    repeat (100) pending_req_q.push_back(rand_req());
    drain_requests(4);

    run_phase(16'd0, 20'd0, 160, 1'b1);
    run_phase(16'd1, 20'd1, 150, 1'b0);
    run_phase(16'd3, 20'd100, 150, 1'b1);
    run_phase(16'd2, 20'd40, 110, 1'b1);
    run_phase(16'hFFFF, 20'hFFFFF, 60, 1'b0);

    drain_requests(8);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
